// ===== sv/bsoc_pkg.sv =====
// Types and constant tables for the battery state of charge unit.
`timescale 1ns / 1ps
`default_nettype none
package bsoc_pkg;

   localparam int TABLE_POINTS = 11;
   localparam int SEG_COUNT    = TABLE_POINTS - 1;
   localparam int SEG_W        = $clog2(TABLE_POINTS);
   localparam int OCV_W        = 13;
   localparam int SOC_W        = 7;
   localparam int DIFF_W       = 9;
   localparam int SEG_RECIP_W  = 15;
   localparam int SEG_SHIFT    = 21;

   typedef enum logic {
      CSR_CELL_COUNT = 1'b0,
      CSR_INT_RES    = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [14:0] pack_mv;
      logic [15:0] active_ma;
      logic        charging;
   } info_type;

   localparam logic [14:0] PACK_BASE_MV   = 15'd2880;
   localparam logic [7:0]  HEAVY_MIN_CODE = 8'd5;
   localparam logic [11:0] RECIP_125      = 12'd2097;
   localparam logic [6:0]  DIV_125        = 7'd125;
   localparam logic [14:0] FRAC_RECIP     = 15'd16778;
   localparam logic [6:0]  SOC_MAX        = 7'd100;

   // floor(2^16 / cells), a zero cell count acts as one
   localparam logic [16:0] CELL_RECIP [16] = '{
      17'd65536, 17'd65536, 17'd32768, 17'd21845, 17'd16384, 17'd13107, 17'd10922, 17'd9362,
      17'd8192,  17'd7281,  17'd6553,  17'd5957,  17'd5461,  17'd5041,  17'd4681,  17'd4369
   };

   localparam logic [OCV_W-1:0] OCV_LIGHT [TABLE_POINTS] = '{
      13'd2600, 13'd3000, 13'd3150, 13'd3300, 13'd3450, 13'd3600,
      13'd3750, 13'd3850, 13'd3940, 13'd4040, 13'd4150
   };

   localparam logic [OCV_W-1:0] OCV_HEAVY [TABLE_POINTS] = '{
      13'd2600, 13'd2900, 13'd3070, 13'd3220, 13'd3370, 13'd3520,
      13'd3670, 13'd3780, 13'd3900, 13'd3980, 13'd4100
   };

   localparam logic [SOC_W-1:0] SOC_POINTS [TABLE_POINTS] = '{
      7'd0, 7'd10, 7'd20, 7'd30, 7'd40, 7'd50, 7'd60, 7'd70, 7'd80, 7'd90, 7'd100
   };

   // ceil(2^21 / span) per segment, exact for every product below 2^21 / span
   localparam logic [SEG_RECIP_W-1:0] RECIP_LIGHT [SEG_COUNT] = '{
      15'd5243,  15'd13982, 15'd13982, 15'd13982, 15'd13982,
      15'd13982, 15'd20972, 15'd23302, 15'd20972, 15'd19066
   };

   localparam logic [SEG_RECIP_W-1:0] RECIP_HEAVY [SEG_COUNT] = '{
      15'd6991,  15'd12337, 15'd13982, 15'd13982, 15'd13982,
      15'd13982, 15'd19066, 15'd17477, 15'd26215, 15'd17477
   };

endpackage
`default_nettype wire

// ===== sv/battery_state_of_charge_unit.sv =====
// Top level: pipelined state of charge estimate from raw charger ADC codes.
// The path from request accept to rsp_valid runs through 12 register stages.
// Throughput: one request per cycle; the whole pipeline advances together and
// holds in place while rsp_valid is high and rsp_ready is low.
// Reset: synchronous, active high; clears all valid bits and loads cell_count = 3
// and internal_resistance_mohm = 100.
`timescale 1ns / 1ps
`default_nettype none
module battery_state_of_charge_unit (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [7:0]  req_voltage_code,
   input  wire logic [7:0]  req_charge_code,
   input  wire logic [7:0]  req_discharge_code,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [14:0]      rsp_pack_voltage_mv,
   output logic [15:0]      rsp_active_current_ma,
   output logic             rsp_charging,
   output logic [6:0]       rsp_charge_percent,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [9:0]  csr_wdata
);

   localparam int STAGES = 11;

   logic adv;

   logic [3:0] cell_count_ff, cell_count_in;
   logic [9:0] int_res_ff, int_res_in;

   logic [STAGES-1:0] vld_ff, vld_in;
   logic              rsp_valid_ff, rsp_valid_in;
   bsoc_pkg::info_type info_ff [STAGES];
   bsoc_pkg::info_type info_in [STAGES];
   bsoc_pkg::info_type rsp_info_ff, rsp_info_in;
   logic [6:0]        rsp_soc_ff, rsp_soc_in;

   logic [7:0]  s1_dcode_ff, s1_dcode_in;
   logic [3:0]  s1_cells_ff, s1_cells_in;
   logic [16:0] s1_crecip_ff, s1_crecip_in;

   logic [31:0] s2_pdiv_ff, s2_pdiv_in;
   logic [17:0] s2_y_ff, s2_y_in;
   logic [7:0]  s2_dcode_ff, s2_dcode_in;
   logic [3:0]  s2_cells_ff, s2_cells_in;

   logic [14:0] s3_qest_ff, s3_qest_in;
   logic [29:0] s3_yprod_ff, s3_yprod_in;
   logic [17:0] s3_y_ff, s3_y_in;
   logic [7:0]  s3_dcode_ff, s3_dcode_in;
   logic [3:0]  s3_cells_ff, s3_cells_in;

   logic [18:0] s4_qc_ff, s4_qc_in;
   logic [14:0] s4_qest_ff, s4_qest_in;
   logic [11:0] s4_aest_ff, s4_aest_in;
   logic [17:0] s4_y_ff, s4_y_in;
   logic [7:0]  s4_dcode_ff, s4_dcode_in;
   logic [3:0]  s4_cells_ff, s4_cells_in;

   logic [14:0] s5_q_ff, s5_q_in;
   logic [18:0] s5_ac_ff, s5_ac_in;
   logic [11:0] s5_aest_ff, s5_aest_in;
   logic [17:0] s5_y_ff, s5_y_in;
   logic [7:0]  s5_dcode_ff, s5_dcode_in;

   logic [14:0] s6_q_ff, s6_q_in;
   logic [11:0] s6_a_ff, s6_a_in;
   logic [6:0]  s6_b_ff, s6_b_in;
   logic [7:0]  s6_dcode_ff, s6_dcode_in;

   logic [14:0] s7_q_ff, s7_q_in;
   logic [11:0] s7_a_ff, s7_a_in;
   logic [20:0] s7_fprod_ff, s7_fprod_in;
   logic [7:0]  s7_dcode_ff, s7_dcode_in;

   logic [15:0] s8_v_ff, s8_v_in;
   logic        s8_heavy_ff, s8_heavy_in;

   logic                               s9_low_ff, s9_low_in;
   logic                               s9_high_ff, s9_high_in;
   logic [bsoc_pkg::DIFF_W-1:0]        s9_diff_ff, s9_diff_in;
   logic [bsoc_pkg::SOC_W-1:0]         s9_s0_ff, s9_s0_in;
   logic [bsoc_pkg::SOC_W-1:0]         s9_ds_ff, s9_ds_in;
   logic [bsoc_pkg::SEG_RECIP_W-1:0]   s9_recip_ff, s9_recip_in;

   logic                               s10_low_ff, s10_low_in;
   logic                               s10_high_ff, s10_high_in;
   logic [15:0]                        s10_num_ff, s10_num_in;
   logic [bsoc_pkg::SOC_W-1:0]         s10_s0_ff, s10_s0_in;
   logic [bsoc_pkg::SEG_RECIP_W-1:0]   s10_recip_ff, s10_recip_in;

   logic                               s11_low_ff, s11_low_in;
   logic                               s11_high_ff, s11_high_in;
   logic [30:0]                        s11_prod_ff, s11_prod_in;
   logic [bsoc_pkg::SOC_W-1:0]         s11_s0_ff, s11_s0_in;

   // stage 1 decode
   logic        charging;
   logic [15:0] dis_ma;
   logic [13:0] chg_ma;

   // stage 5 and 6 corrections
   logic [14:0] pack_rem;
   logic [17:0] y_rem;
   logic        y_rem_hi;

   // stage 8 compensation
   logic [16:0] comp;
   logic [17:0] v_sum;

   // stage 9 segment search
   logic [bsoc_pkg::OCV_W-1:0] tab [bsoc_pkg::TABLE_POINTS];
   logic [bsoc_pkg::SEG_W-1:0] seg;

   // output stage
   logic [9:0]  step;
   logic [10:0] soc_sum;

   assign adv       = !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign csr_ready = 1'b1;

   always_comb begin
      cell_count_in = cell_count_ff;
      int_res_in    = int_res_ff;
      if (csr_valid) begin
         unique case (bsoc_pkg::csr_index_type'(csr_index))
            bsoc_pkg::CSR_CELL_COUNT: cell_count_in = csr_wdata[3:0];
            bsoc_pkg::CSR_INT_RES:    int_res_in    = csr_wdata;
            default:                  cell_count_in = cell_count_ff;
         endcase
      end
   end

   always_comb begin
      vld_in       = {vld_ff[STAGES-2:0], req_valid};
      rsp_valid_in = adv ? vld_ff[STAGES-1] : rsp_valid_ff;
      if (!adv) begin
         vld_in = vld_ff;
      end
   end

   always_comb begin
      // stage 1: decode ADC codes
      charging = req_charge_code != 8'd0;
      chg_ma   = {req_charge_code, 6'd0};
      dis_ma   = {req_discharge_code, 8'd0};
      info_in[0].pack_mv   = (req_voltage_code == 8'd0) ? 15'd0 :
                             bsoc_pkg::PACK_BASE_MV + {1'b0, req_voltage_code, 6'd0};
      info_in[0].active_ma = charging ? {2'd0, chg_ma} : dis_ma;
      info_in[0].charging  = charging;
      s1_dcode_in  = charging ? 8'd0 : req_discharge_code;
      s1_cells_in  = (cell_count_ff == 4'd0) ? 4'd1 : cell_count_ff;
      s1_crecip_in = bsoc_pkg::CELL_RECIP[cell_count_ff];
      for (int k = 1; k < STAGES; k++) begin
         info_in[k] = info_ff[k-1];
      end

      // stage 2: reciprocal product for the cell divide, discharge code times resistance
      s2_pdiv_in  = 32'(info_ff[0].pack_mv * s1_crecip_ff);
      s2_y_in     = 18'(s1_dcode_ff * int_res_ff);
      s2_dcode_in = s1_dcode_ff;
      s2_cells_in = s1_cells_ff;

      // stage 3: quotient estimate, y / 125 reciprocal product
      s3_qest_in  = s2_pdiv_ff[30:16];
      s3_yprod_in = 30'(s2_y_ff * bsoc_pkg::RECIP_125);
      s3_y_in     = s2_y_ff;
      s3_dcode_in = s2_dcode_ff;
      s3_cells_in = s2_cells_ff;

      // stage 4: back-multiply cell quotient
      s4_qc_in    = 19'(s3_qest_ff * s3_cells_ff);
      s4_qest_in  = s3_qest_ff;
      s4_aest_in  = s3_yprod_ff[29:18];
      s4_y_in     = s3_y_ff;
      s4_dcode_in = s3_dcode_ff;
      s4_cells_in = s3_cells_ff;

      // stage 5: correct cell quotient, back-multiply y / 125
      pack_rem    = info_ff[3].pack_mv - s4_qc_ff[14:0];
      s5_q_in     = s4_qest_ff + 15'(pack_rem >= {11'd0, s4_cells_ff});
      s5_ac_in    = 19'(s4_aest_ff * bsoc_pkg::DIV_125);
      s5_aest_in  = s4_aest_ff;
      s5_y_in     = s4_y_ff;
      s5_dcode_in = s4_dcode_ff;

      // stage 6: correct y / 125, keep remainder
      y_rem       = s5_y_ff - s5_ac_ff[17:0];
      y_rem_hi    = y_rem >= {11'd0, bsoc_pkg::DIV_125};
      s6_a_in     = s5_aest_ff + 12'(y_rem_hi);
      s6_b_in     = y_rem_hi ? 7'(y_rem - {11'd0, bsoc_pkg::DIV_125}) : y_rem[6:0];
      s6_q_in     = s5_q_ff;
      s6_dcode_in = s5_dcode_ff;

      // stage 7: floor(32 * b / 125)
      s7_fprod_in = 21'(s6_b_ff * bsoc_pkg::FRAC_RECIP);
      s7_a_in     = s6_a_ff;
      s7_q_in     = s6_q_ff;
      s7_dcode_in = s6_dcode_ff;

      // stage 8: compensated cell voltage
      comp  = {s7_a_ff, 5'd0} + {12'd0, s7_fprod_ff[20:16]};
      v_sum = {3'd0, s7_q_ff} + {1'b0, comp};
      if (s7_dcode_ff == 8'd0) begin
         s8_v_in = {1'b0, s7_q_ff};
      end else if (v_sum[17:16] != 2'd0) begin
         s8_v_in = 16'hFFFF;
      end else begin
         s8_v_in = v_sum[15:0];
      end
      s8_heavy_in = s7_dcode_ff >= bsoc_pkg::HEAVY_MIN_CODE;

      // stage 9: segment search
      for (int k = 0; k < bsoc_pkg::TABLE_POINTS; k++) begin
         tab[k] = s8_heavy_ff ? bsoc_pkg::OCV_HEAVY[k] : bsoc_pkg::OCV_LIGHT[k];
      end
      seg = '0;
      for (int k = 1; k < bsoc_pkg::SEG_COUNT; k++) begin
         seg = seg + bsoc_pkg::SEG_W'(s8_v_ff > {3'd0, tab[k]});
      end
      s9_low_in   = s8_v_ff <= {3'd0, tab[0]};
      s9_high_in  = s8_v_ff >= {3'd0, tab[bsoc_pkg::TABLE_POINTS-1]};
      s9_diff_in  = bsoc_pkg::DIFF_W'(s8_v_ff - {3'd0, tab[seg]});
      s9_s0_in    = bsoc_pkg::SOC_POINTS[seg];
      s9_ds_in    = bsoc_pkg::SOC_POINTS[seg + bsoc_pkg::SEG_W'(1)] -
                    bsoc_pkg::SOC_POINTS[seg];
      s9_recip_in = s8_heavy_ff ? bsoc_pkg::RECIP_HEAVY[seg] : bsoc_pkg::RECIP_LIGHT[seg];

      // stage 10: numerator
      s10_num_in   = 16'(s9_diff_ff * s9_ds_ff);
      s10_low_in   = s9_low_ff;
      s10_high_in  = s9_high_ff;
      s10_s0_in    = s9_s0_ff;
      s10_recip_in = s9_recip_ff;

      // stage 11: divide by span through its reciprocal
      s11_prod_in = 31'(s10_num_ff * s10_recip_ff);
      s11_low_in  = s10_low_ff;
      s11_high_in = s10_high_ff;
      s11_s0_in   = s10_s0_ff;

      // output stage
      step        = s11_prod_ff[30:bsoc_pkg::SEG_SHIFT];
      soc_sum     = {4'd0, s11_s0_ff} + {1'b0, step};
      rsp_info_in = info_ff[STAGES-1];
      priority if (s11_low_ff) begin
         rsp_soc_in = 7'd0;
      end else if (s11_high_ff || soc_sum > {4'd0, bsoc_pkg::SOC_MAX}) begin
         rsp_soc_in = bsoc_pkg::SOC_MAX;
      end else begin
         rsp_soc_in = soc_sum[6:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_count_ff <= 4'd3;
         int_res_ff    <= 10'd100;
         vld_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cell_count_ff <= cell_count_in;
         int_res_ff    <= int_res_in;
         vld_ff        <= vld_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int k = 0; k < STAGES; k++) begin
            info_ff[k] <= info_in[k];
         end
         rsp_info_ff  <= rsp_info_in;
         rsp_soc_ff   <= rsp_soc_in;
         s1_dcode_ff  <= s1_dcode_in;
         s1_cells_ff  <= s1_cells_in;
         s1_crecip_ff <= s1_crecip_in;
         s2_pdiv_ff   <= s2_pdiv_in;
         s2_y_ff      <= s2_y_in;
         s2_dcode_ff  <= s2_dcode_in;
         s2_cells_ff  <= s2_cells_in;
         s3_qest_ff   <= s3_qest_in;
         s3_yprod_ff  <= s3_yprod_in;
         s3_y_ff      <= s3_y_in;
         s3_dcode_ff  <= s3_dcode_in;
         s3_cells_ff  <= s3_cells_in;
         s4_qc_ff     <= s4_qc_in;
         s4_qest_ff   <= s4_qest_in;
         s4_aest_ff   <= s4_aest_in;
         s4_y_ff      <= s4_y_in;
         s4_dcode_ff  <= s4_dcode_in;
         s4_cells_ff  <= s4_cells_in;
         s5_q_ff      <= s5_q_in;
         s5_ac_ff     <= s5_ac_in;
         s5_aest_ff   <= s5_aest_in;
         s5_y_ff      <= s5_y_in;
         s5_dcode_ff  <= s5_dcode_in;
         s6_q_ff      <= s6_q_in;
         s6_a_ff      <= s6_a_in;
         s6_b_ff      <= s6_b_in;
         s6_dcode_ff  <= s6_dcode_in;
         s7_q_ff      <= s7_q_in;
         s7_a_ff      <= s7_a_in;
         s7_fprod_ff  <= s7_fprod_in;
         s7_dcode_ff  <= s7_dcode_in;
         s8_v_ff      <= s8_v_in;
         s8_heavy_ff  <= s8_heavy_in;
         s9_low_ff    <= s9_low_in;
         s9_high_ff   <= s9_high_in;
         s9_diff_ff   <= s9_diff_in;
         s9_s0_ff     <= s9_s0_in;
         s9_ds_ff     <= s9_ds_in;
         s9_recip_ff  <= s9_recip_in;
         s10_low_ff   <= s10_low_in;
         s10_high_ff  <= s10_high_in;
         s10_num_ff   <= s10_num_in;
         s10_s0_ff    <= s10_s0_in;
         s10_recip_ff <= s10_recip_in;
         s11_low_ff   <= s11_low_in;
         s11_high_ff  <= s11_high_in;
         s11_prod_ff  <= s11_prod_in;
         s11_s0_ff    <= s11_s0_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_pack_voltage_mv   = rsp_info_ff.pack_mv;
   assign rsp_active_current_ma = rsp_info_ff.active_ma;
   assign rsp_charging          = rsp_info_ff.charging;
   assign rsp_charge_percent    = rsp_soc_ff;

endmodule
`default_nettype wire

// ===== sv/bsoc_checker.sv =====
// Port-level checks for the battery state of charge unit, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module bsoc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [14:0] rsp_pack_voltage_mv,
   input wire logic [15:0] rsp_active_current_ma,
   input wire logic        rsp_charging,
   input wire logic [6:0]  rsp_charge_percent
);

   a_soc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_charge_percent <= 7'd100)
      else $error("state of charge above 100");

   a_charge_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_charging |->
         rsp_active_current_ma != 16'd0 && rsp_active_current_ma[15:14] == 2'd0 &&
         rsp_active_current_ma[5:0] == 6'd0)
      else $error("charging request with bad charge current");

   a_discharge_current: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_charging |-> rsp_active_current_ma[7:0] == 8'd0)
      else $error("discharge current not a multiple of 256 mA");

   a_pack_voltage: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pack_voltage_mv != 15'd0 |->
         rsp_pack_voltage_mv >= 15'd2944 && rsp_pack_voltage_mv <= 15'd19200 &&
         rsp_pack_voltage_mv[5:0] == 6'd0)
      else $error("pack voltage off the ADC grid");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_charge_percent) &&
         $stable(rsp_pack_voltage_mv))
      else $error("stalled response changed");

endmodule

bind battery_state_of_charge_unit bsoc_checker u_bsoc_checker (.*);
`default_nettype wire
